// ===== rtl/core/sqgd_pkg.sv =====
// Shared types, constants and item layouts for the squelch gate delay block.
package sqgd_pkg;

    // Gate delay store geometry.
    localparam int DELAY_DEPTH = 32768;
    localparam int DELAY_AW    = (DELAY_DEPTH > 1) ? $clog2(DELAY_DEPTH) : 1;
    localparam int FILL_W      = $clog2(DELAY_DEPTH + 1);

    // Scope tap length and output block length.
    localparam int SCOPE_DELAY = 10;
    localparam int BLOCK_LEN   = 4096;
    localparam int BLOCK_W     = (BLOCK_LEN > 1) ? $clog2(BLOCK_LEN) : 1;

    // Reset values of the configuration registers.
    localparam logic [31:0] THRESHOLD_RESET = 32'd107374;
    localparam logic [14:0] GATE_RESET      = 15'd0;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_POWER_THRESHOLD = 1'b0,
        REG_GATE_SAMPLES    = 1'b1
    } cfg_reg_t;

    // Input item.
    typedef struct packed {
        logic signed [15:0] demod_sample;
        logic        [31:0] power_avg;
    } in_item_t;

    // Result item.
    typedef struct packed {
        logic signed [15:0] gated_sample;
        logic signed [15:0] scope_delayed;
        logic               squelch_open;
        logic               carrier_lost;
        logic               block_last;
    } out_item_t;

    // Control and data carried from the front stage to the memory read stage.
    typedef struct packed {
        logic signed [15:0] wdata;
        logic               open;
        logic               use_mem;
        logic               fwd;
        logic               written;
        logic               lost;
        logic               last;
    } stage_t;

    // Write and read request to the gate delay store.
    typedef struct packed {
        logic                wr_en;
        logic [DELAY_AW-1:0] wr_addr;
        logic [15:0]         wr_data;
        logic                rd_en;
        logic [DELAY_AW-1:0] rd_addr;
    } mem_req_t;

endpackage

// ===== rtl/core/sqgd_delay_mem.sv =====
// Gate delay store: one write port and one registered read port.
module sqgd_delay_mem
    import sqgd_pkg::*;
(
    input  logic        clk,
    input  mem_req_t    req,
    output logic [15:0] rd_data
);

    logic [15:0] mem [DELAY_DEPTH];
    logic [15:0] rd_data_reg;

    // Write port; entries never written are masked by the fill count upstream.
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    // Registered read port, old data on a same-address write.
    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/sqgd_ctrl.sv =====
// Front stage: configuration, power compare, hang counter and delay pointers.
module sqgd_ctrl
    import sqgd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 fire,
    input  in_item_t             item,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data,
    output mem_req_t             mem_req,
    output stage_t               stage
);

    logic [31:0]         thr_reg;
    logic [14:0]         gate_reg;
    logic [15:0]         cnt_reg;
    logic [15:0]         cnt_next;
    logic [DELAY_AW-1:0] wp_reg;
    logic [DELAY_AW-1:0] wp_next;
    logic [FILL_W-1:0]   fill_reg;
    logic [FILL_W-1:0]   fill_next;
    logic                was_open_reg;
    logic [BLOCK_W-1:0]  blk_reg;
    logic [BLOCK_W-1:0]  blk_next;

    logic                high;
    logic                gate_on;
    logic                open;
    logic                last;
    logic [31:0]         back_len;
    logic [31:0]         wpn_ext;
    logic [31:0]         rd_ext;
    logic [DELAY_AW-1:0] rd_addr;
    logic signed [15:0]  wdata;

    // Power compare and the hang counter step.
    always_comb
    begin
        high    = item.power_avg > thr_reg;
        gate_on = gate_reg != 15'd0;
        cnt_next = cnt_reg;
        if (high)
        begin
            if (cnt_reg < {gate_reg, 1'b0})
            begin
                cnt_next = cnt_reg + 16'd1;
            end
        end
        else if (cnt_reg != 16'd0)
        begin
            cnt_next = cnt_reg - 16'd1;
        end
        open  = gate_on ? (cnt_next > {1'b0, gate_reg}) : high;
        wdata = high ? item.demod_sample : 16'sd0;
    end

    // Write pointer, fill count and read address of the delayed entry.
    always_comb
    begin
        wp_next = (32'(wp_reg) == DELAY_DEPTH - 1) ? '0 : wp_reg + DELAY_AW'(1);
        fill_next = (32'(fill_reg) == DELAY_DEPTH) ? fill_reg : fill_reg + FILL_W'(1);
        back_len = (32'(gate_reg) > DELAY_DEPTH) ? 32'(DELAY_DEPTH) : 32'(gate_reg);
        wpn_ext  = 32'(wp_next);
        rd_ext   = (wpn_ext >= back_len) ? (wpn_ext - back_len)
                                         : (wpn_ext + 32'(DELAY_DEPTH) - back_len);
        rd_addr  = rd_ext[DELAY_AW-1:0];
    end

    // Output block position.
    always_comb
    begin
        last     = blk_reg == BLOCK_W'(BLOCK_LEN - 1);
        blk_next = last ? '0 : blk_reg + BLOCK_W'(1);
    end

    // Memory request and the item handed to the read stage.
    always_comb
    begin
        mem_req.wr_en   = fire && gate_on;
        mem_req.wr_addr = wp_reg;
        mem_req.wr_data = wdata;
        mem_req.rd_en   = fire && gate_on;
        mem_req.rd_addr = rd_addr;

        stage.wdata   = wdata;
        stage.open    = open;
        stage.use_mem = gate_on;
        stage.fwd     = rd_addr == wp_reg;
        stage.written = 32'(fill_next) >= back_len;
        stage.lost    = !open && was_open_reg;
        stage.last    = last;
    end

    // Configuration registers and per-item state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg      <= THRESHOLD_RESET;
            gate_reg     <= GATE_RESET;
            cnt_reg      <= '0;
            wp_reg       <= '0;
            fill_reg     <= '0;
            was_open_reg <= 1'b0;
            blk_reg      <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_POWER_THRESHOLD:
                begin
                    thr_reg <= cfg_data;
                end
                REG_GATE_SAMPLES:
                begin
                    gate_reg <= cfg_data[14:0];
                    cnt_reg  <= '0;
                end
                default:
                begin
                end
            endcase
        end
        else if (fire)
        begin
            if (gate_on)
            begin
                cnt_reg  <= cnt_next;
                wp_reg   <= wp_next;
                fill_reg <= fill_next;
            end
            was_open_reg <= open;
            blk_reg      <= blk_next;
        end
    end

endmodule

// ===== rtl/core/sqgd_out.sv =====
// Read stage, scope tap line and the output register.
module sqgd_out
    import sqgd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        fire,
    input  stage_t      stage,
    input  logic [15:0] rd_data,
    output logic        in_stall,
    output logic        out_valid,
    input  logic        out_stall,
    output out_item_t   out_data
);

    logic               s1_valid_reg;
    stage_t             s1_reg;
    logic               out_valid_reg;
    out_item_t          out_reg;
    logic signed [15:0] scope_reg [SCOPE_DELAY];
    logic               adv;
    logic               move;
    logic signed [15:0] gated;

    // Stage handshake: the read stage drains into the output register.
    always_comb
    begin
        adv      = !out_valid_reg || !out_stall;
        move     = s1_valid_reg && adv;
        in_stall = s1_valid_reg && !adv;
    end

    // Pick the gated sample: stored entry, forwarded write or current sample.
    always_comb
    begin
        if (!s1_reg.open)
        begin
            gated = 16'sd0;
        end
        else if (s1_reg.use_mem && !s1_reg.fwd)
        begin
            gated = s1_reg.written ? $signed(rd_data) : 16'sd0;
        end
        else
        begin
            gated = s1_reg.wdata;
        end
    end

    // Valid flags of the two stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= fire || (s1_valid_reg && !adv);
            out_valid_reg <= move || (out_valid_reg && out_stall);
        end
    end

    // Read stage payload.
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            s1_reg <= stage;
        end
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        if (move)
        begin
            out_reg.gated_sample  <= gated;
            out_reg.scope_delayed <= scope_reg[SCOPE_DELAY-1];
            out_reg.squelch_open  <= s1_reg.open;
            out_reg.carrier_lost  <= s1_reg.lost;
            out_reg.block_last    <= s1_reg.last;
        end
    end

    // Scope tap line shifts once per delivered item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SCOPE_DELAY; i++)
            begin
                scope_reg[i] <= 16'sd0;
            end
        end
        else if (move)
        begin
            scope_reg[0] <= gated;
            for (int i = 1; i < SCOPE_DELAY; i++)
            begin
                scope_reg[i] <= scope_reg[i-1];
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// ===== rtl/core/squelch_gate_delay_core.sv =====
// Top level of the squelch gate delay block.
//
//  Channel  Direction  Handshake            Payload
//  in       in         in_valid/in_stall    in_data    (in_item_t)
//  out      out        out_valid/out_stall  out_data   (out_item_t)
//  cfg      in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One item per cycle while out_stall stays low; an accepted item is held in the read
// stage for the registered read of the gate delay store, then moves into the output
// register, from which it shows on out_data and leaves when out_stall is low.
// Reset is asynchronous and active low; the store needs no clearing pass, a
// fill count marks which entries have been written.
// A stall on the output holds the read stage, and in_stall rises only once
// both the read stage and the output register are occupied.
module squelch_gate_delay_core
    import sqgd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  in_item_t             in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output out_item_t            out_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data
);

    logic        fire;
    mem_req_t    mem_req;
    stage_t      stage;
    logic [15:0] rd_data;

    // Configuration is always taken.
    assign cfg_ready = 1'b1;
    assign fire      = in_valid && !in_stall;

    sqgd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .item      (in_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .mem_req   (mem_req),
        .stage     (stage)
    );

    sqgd_delay_mem u_mem (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    sqgd_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .stage     (stage),
        .rd_data   (rd_data),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

// ===== rtl/core/sqgd_checker.sv =====
// Port-level checks for the squelch gate delay block, bound to the top level.
module sqgd_checker
    import sqgd_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_stall,
    input logic      out_valid,
    input logic      out_stall,
    input out_item_t out_data
);

    // A stalled result item stays and holds its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled output item changed");

    // The input is held back only when the output side is full and stalled.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output backpressure");

    // A closed squelch delivers silence.
    a_closed_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.squelch_open |-> out_data.gated_sample == 16'sd0)
        else $error("closed squelch passed a nonzero sample");

    // Carrier loss is only flagged on a closed item.
    a_lost_closed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.carrier_lost |-> !out_data.squelch_open)
        else $error("carrier lost flagged while open");

endmodule

bind squelch_gate_delay_core sqgd_checker u_sqgd_checker (.*);

// ===== tb/sv/squelch_gate_delay_core_tb.sv =====
// Self-checking testbench for the squelch gate delay core with a predicting scoreboard.
module squelch_gate_delay_core_tb;
    import sqgd_pkg::*;

    // Expected-result scoreboard with its own model of the squelch, gate delay and scope tap.
    class squelch_scoreboard;
        logic [31:0]        threshold;
        logic [14:0]        gate;
        int unsigned        hang_count;
        logic signed [15:0] gate_line [DELAY_DEPTH];
        int unsigned        gate_wr_ptr;
        bit                 was_open;
        logic signed [15:0] scope_line [SCOPE_DELAY];
        int unsigned        scope_ptr;
        int unsigned        block_count;
        out_item_t          due_outputs [$];
        int unsigned        mismatches;
        int unsigned        results_seen;

        function new();
            threshold    = THRESHOLD_RESET;
            gate         = GATE_RESET;
            hang_count   = 0;
            gate_wr_ptr  = 0;
            was_open     = 1'b0;
            scope_ptr    = 0;
            block_count  = 0;
            mismatches   = 0;
            results_seen = 0;
            foreach (gate_line[i]) gate_line[i] = '0;
            foreach (scope_line[i]) scope_line[i] = '0;
        endfunction

        // A gate write also clears the hang counter.
        function void write_reg(cfg_reg_t idx, logic [31:0] value);
            if (idx == REG_POWER_THRESHOLD) begin
                threshold = value;
            end
            else if (idx == REG_GATE_SAMPLES) begin
                gate       = value[14:0];
                hang_count = 0;
            end
        endfunction

        // Work out the result of one accepted item and queue it.
        function void note_input(in_item_t item);
            out_item_t   want;
            bit          high;
            bit          open;
            int unsigned gate_n;
            int unsigned back;
            logic signed [15:0] gated;

            high   = item.power_avg > threshold;
            gate_n = gate;
            gated  = '0;
            if (gate_n != 0) begin
                if (high) begin
                    if (hang_count < 2 * gate_n)
                        hang_count++;
                end
                else if (hang_count > 0) begin
                    hang_count--;
                end
                hang_count &= 32'hFFFF;
                gate_line[gate_wr_ptr] = high ? item.demod_sample : 16'sd0;
                gate_wr_ptr = (gate_wr_ptr + 1) % DELAY_DEPTH;
                open = hang_count > gate_n;
                back = (gate_n > DELAY_DEPTH) ? DELAY_DEPTH : gate_n;
                if (open)
                    gated = gate_line[(gate_wr_ptr + DELAY_DEPTH - back) % DELAY_DEPTH];
            end
            else begin
                open = high;
                if (open)
                    gated = item.demod_sample;
            end

            want.gated_sample  = gated;
            want.squelch_open  = open;
            want.carrier_lost  = !open && was_open;
            was_open = open;

            block_count++;
            want.block_last = 1'b0;
            if (block_count >= BLOCK_LEN) begin
                want.block_last = 1'b1;
                block_count     = 0;
            end

            want.scope_delayed    = scope_line[scope_ptr];
            scope_line[scope_ptr] = gated;
            scope_ptr = (scope_ptr + 1) % SCOPE_DELAY;

            due_outputs = {due_outputs, want};
        endfunction

        // Print one line for the mismatch and count it.
        task report_mismatch(string what);
            mismatches++;
            $display("mismatch at result %0d: %s", results_seen, what);
        endtask

        // Compare a result with the oldest expected one, field by field.
        task check_result(out_item_t got);
            out_item_t want;
            if (due_outputs.size() == 0) begin
                report_mismatch("result arrived with no item outstanding");
            end
            else begin
                want = due_outputs.pop_front();
                if (got.gated_sample !== want.gated_sample)
                    report_mismatch($sformatf("gated_sample got %0d want %0d",
                                              got.gated_sample, want.gated_sample));
                if (got.scope_delayed !== want.scope_delayed)
                    report_mismatch($sformatf("scope_delayed got %0d want %0d",
                                              got.scope_delayed, want.scope_delayed));
                if (got.squelch_open !== want.squelch_open)
                    report_mismatch($sformatf("squelch_open got %b want %b",
                                              got.squelch_open, want.squelch_open));
                if (got.carrier_lost !== want.carrier_lost)
                    report_mismatch($sformatf("carrier_lost got %b want %b",
                                              got.carrier_lost, want.carrier_lost));
                if (got.block_last !== want.block_last)
                    report_mismatch($sformatf("block_last got %b want %b",
                                              got.block_last, want.block_last));
            end
            results_seen++;
        endtask

        // Anything still outstanding at the end is a failure.
        task check_drained();
            if (due_outputs.size() != 0)
                report_mismatch($sformatf("%0d results never arrived", due_outputs.size()));
        endtask
    endclass

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    in_item_t   in_data;
    logic       out_valid;
    logic       out_stall;
    out_item_t  out_data;
    logic       cfg_valid;
    logic       cfg_ready;
    cfg_reg_t   cfg_index;
    logic [31:0] cfg_data;

    squelch_scoreboard sb;
    bit idle_en;

    squelch_gate_delay_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Clock with a period of 8.
    initial clk = 1'b0;
    always #4 clk = ~clk;

    // Hard limit on the run time.
    initial
    begin
        #3200000;
        $display("FAILURE");
        $finish;
    end

    // Receiver stalls in random bursts while idling is enabled.
    initial
    begin
        int n;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (idle_en && $urandom_range(0, 5) == 0)
            begin
                n = $urandom_range(1, 7);
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
        end
    end

    // Check every result that leaves the block.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(out_data);
    end

    // Write one configuration register and note it in the scoreboard.
    task automatic write_reg(cfg_reg_t idx, logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        sb.write_reg(idx, value);
        @(posedge clk);
    endtask

    // Offer one item, with a random gap first, and wait until it is taken.
    task automatic send_item(logic signed [15:0] sample, logic [31:0] power);
        in_item_t item;
        item.demod_sample = sample;
        item.power_avg    = power;
        if (idle_en && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_input(item);
    endtask

    // Stop sending and wait until every expected result has come.
    task automatic drain_block();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.due_outputs.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Pick a power level on the wanted side of the threshold, often right at it.
    function automatic logic [31:0] pick_power(bit want_high, logic [31:0] thr);
        if (want_high)
        begin
            if (thr == 32'hFFFFFFFF)
                return thr;
            if ($urandom_range(0, 3) == 0)
                return thr + 1;
            return $urandom_range(32'hFFFFFFFF, thr + 1);
        end
        if ($urandom_range(0, 3) == 0)
            return thr;
        return $urandom_range(thr, 0);
    endfunction

    // Carrier bursts with random content, some pure noise items among them.
    task automatic run_bursts(int count, bit pressure);
        int          sent;
        int          run_len;
        int unsigned g;
        bit          carrier;
        sent    = 0;
        carrier = 1'b0;
        g       = (sb.gate > 20) ? 20 : sb.gate;
        while (sent < count)
        begin
            carrier = !carrier;
            run_len = carrier ? $urandom_range(1, 2 * g + 4) : $urandom_range(1, g + 4);
            while (run_len > 0 && sent < count)
            begin
                if (pressure && sent == count / 2)
                    drain_block();
                if ($urandom_range(0, 9) == 0)
                    send_item(16'($urandom), $urandom);
                else
                    send_item(16'($urandom), pick_power(carrier, sb.threshold));
                run_len--;
                sent++;
            end
        end
    endtask

    // Main sequence.
    initial
    begin
        logic [31:0] thr;
        logic [14:0] gate;
        int          i;

        sb        = new();
        idle_en   = 1'b1;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_POWER_THRESHOLD;
        cfg_data  <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Gate off at reset values: squelch follows the power compare directly.
        thr = THRESHOLD_RESET;
        send_item(16'sd32767, thr + 1);
        send_item(16'sh8000, 32'hFFFFFFFF);
        send_item(16'sd0, thr);
        send_item(-16'sd1, 32'd0);
        send_item(16'sd1, thr + 1);
        send_item(16'sd12345, thr - 1);
        send_item(-16'sd1, 32'hFFFFFFFF);
        send_item(16'sh5555, thr + 1);
        send_item(-16'sd21846, thr + 1);
        send_item(16'sd100, 32'd0);
        send_item(-16'sd100, thr + 1);
        send_item(16'sd7, thr + 1);
        drain_block();

        // A gate of one: opens on the second strong item and passes the current one.
        write_reg(REG_GATE_SAMPLES, 32'd1);
        send_item(16'sd111, thr + 1);
        send_item(16'sd222, thr + 1);
        send_item(16'sd333, thr + 1);
        send_item(16'sd444, thr);
        send_item(16'sd555, 32'hFFFFFFFF);
        send_item(16'sd666, 32'd0);
        send_item(16'sd777, 32'd0);
        drain_block();

        // Threshold extremes with the gate off.
        write_reg(REG_GATE_SAMPLES, 32'd0);
        write_reg(REG_POWER_THRESHOLD, 32'd0);
        send_item(16'sd5, 32'd0);
        send_item(16'sd6, 32'd1);
        drain_block();
        write_reg(REG_POWER_THRESHOLD, 32'hFFFFFFFF);
        send_item(16'sd7, 32'hFFFFFFFF);
        drain_block();

        // Random phases over a spread of settings.
        for (i = 0; i < 8; i++)
        begin
            unique case (i)
                0:       begin thr = 32'd0;         gate = 15'd2;     end
                1:       begin thr = 32'hFFFFFFFF;  gate = 15'd0;     end
                2:       begin thr = $urandom;      gate = 15'd32767; end
                3:       begin thr = $urandom;      gate = 15'd1;     end
                4:       begin thr = $urandom;      gate = 15'($urandom_range(3, 16));  end
                5:       begin thr = THRESHOLD_RESET; gate = 15'($urandom_range(17, 60)); end
                6:       begin thr = $urandom;      gate = 15'd0;     end
                default: begin thr = $urandom;      gate = 15'($urandom_range(3, 40));  end
            endcase
            idle_en = ($urandom_range(0, 3) != 0);
            write_reg(REG_POWER_THRESHOLD, thr);
            write_reg(REG_GATE_SAMPLES, {17'd0, gate});
            run_bursts(30, i == 4);
            drain_block();
        end

        // Longer gate with a mostly present carrier, no idling: the gate opens late.
        idle_en = 1'b0;
        write_reg(REG_POWER_THRESHOLD, 32'h4000_0000);
        write_reg(REG_GATE_SAMPLES, 32'd50);
        for (i = 0; i < 150; i++)
        begin
            if ($urandom_range(0, 15) == 0)
                send_item(16'($urandom), pick_power(1'b0, 32'h4000_0000));
            else
                send_item(16'($urandom), pick_power(1'b1, 32'h4000_0000));
        end
        drain_block();
        repeat (10) @(posedge clk);

        sb.check_drained();
        if (sb.mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/sqgd_pkg.sv
rtl/core/sqgd_delay_mem.sv
rtl/core/sqgd_ctrl.sv
rtl/core/sqgd_out.sv
rtl/core/squelch_gate_delay_core.sv
rtl/core/sqgd_checker.sv
tb/sv/squelch_gate_delay_core_tb.sv
